// ----- sv/mctd_pkg.sv -----
// Package: shared types and constants of the code tracer decoder.
`timescale 1ns / 1ps
package mctd_pkg;
  typedef enum logic [2:0] {
    T_NONE  = 3'd0,
    T_SKIP  = 3'd1,
    T_W16   = 3'd2,
    T_L32   = 3'd3,
    T_IDX   = 3'd4,
    T_PCIDX = 3'd5
  } item_type_e;

  localparam logic [1:0] K_DATA   = 2'd0;
  localparam logic [1:0] K_ALTER  = 2'd1;
  localparam logic [1:0] K_BRANCH = 2'd2;
  localparam logic [1:0] K_SUB    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_STOP    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_UNHAND  = 2'd3;

  localparam logic [15:0] FMT_FULL  = 16'h0100;
  localparam logic [15:0] FMT_BS    = 16'h0080;
  localparam logic [15:0] OP_BIT11  = 16'h0800;

  typedef struct packed {
    item_type_e  kind_t;
    logic [1:0]  kind;
    logic [2:0]  cnt;
  } plan_item_t;

  typedef struct packed {
    logic [15:0] code_word;
    logic [31:0] word_address;
    logic        restart;
  } in_word_t;

  typedef struct packed {
    logic        ref_valid;
    logic [31:0] ref_address;
    logic [1:0]  target_kind;
    logic        instr_done;
    logic [31:0] instr_start;
    logic [31:0] instr_next;
    logic [1:0]  end_status;
    logic        last;
  } out_word_t;
endpackage

// ----- sv/mctd_if.sv -----
// Interfaces: valid/ready channels for input and result words.
`timescale 1ns / 1ps
interface mctd_in_if import mctd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mctd_out_if import mctd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/m68k_code_tracer_decoder.sv -----
// Top level: 68000 instruction length decoder and code reference tracer.
//
// Channel   Direction  Payload
// in_ch     sink       code_word, word_address, restart
// out_ch    source     ref_*, target_kind, instr_*, end_status, last
//
// One word is taken per cycle while the result is not stalled: it is captured in
// an input register, then decoded, and the result register and the trace state
// are loaded from it; the rate is set by the single decode pass.
// Reset clears the input and result valid flags and the decode phase.
// A stalled result holds the pipeline; the input register refills as soon
// as the result register frees.
`timescale 1ns / 1ps
module m68k_code_tracer_decoder import mctd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  mctd_in_if.sink   in_ch,
  mctd_out_if.source out_ch
);
  localparam logic [1:0] PH_OPCODE = 2'd0;
  localparam logic [1:0] PH_EXT    = 2'd1;
  localparam logic [1:0] PH_IDXEXT = 2'd2;

  logic        iv_q;
  in_word_t    ir_q;
  logic        ov_q;
  out_word_t   or_q;
  logic        adv;

  logic [1:0]  phase_q, phase_d;
  plan_item_t  plan_q [3], plan_d [3];
  logic [1:0]  pcnt_q, pcnt_d;
  logic [2:0]  wl_q, wl_d;
  logic [15:0] hh_q, hh_d;
  logic [31:0] rb_q, rb_d;
  logic [15:0] ifw_q, ifw_d;
  logic [2:0]  osz_q, osz_d;
  logic        pr_q, pr_d;
  logic [31:0] isa_q, isa_d;
  logic [1:0]  stl_q, stl_d;

  logic        emit_v;
  logic [31:0] emit_a;
  logic [1:0]  emit_k;
  logic        done;
  logic [1:0]  st;
  logic [31:0] off;

  assign adv = iv_q && (!ov_q || out_ch.ready);
  assign in_ch.ready = !iv_q || adv;

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction
  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction
  function automatic logic [2:0] fw(input logic [1:0] s);
    return (s == 2'd2) ? 3'd1 : ((s == 2'd3) ? 3'd2 : 3'd0);
  endfunction

  function automatic void start_item(input plan_item_t p, output logic [2:0] wl,
                                     output logic [1:0] ph);
    if (p.kind_t == T_SKIP) wl = p.cnt;
    else if (p.kind_t == T_L32) wl = 3'd2;
    else wl = 3'd1;
    ph = PH_EXT;
  endfunction

  function automatic void push(inout plan_item_t pl [3], inout logic [1:0] pc,
                               input item_type_e t, input logic [1:0] k,
                               input logic [2:0] n);
    if (pc < 2'd3) begin
      pl[pc[1:0]] = '{kind_t: t, kind: k, cnt: n};
      pc = pc + 2'd1;
    end
  endfunction

  function automatic void ea(input logic [3:0] mode, input logic [7:0] rg,
                             input logic [1:0] k, input logic [31:0] addr,
                             input logic [2:0] osz, inout plan_item_t pl [3],
                             inout logic [1:0] pc, inout logic ev,
                             inout logic [31:0] ea_a, inout logic [1:0] ek);
    unique case (mode)
      4'd5: push(pl, pc, T_SKIP, k, 3'd1);
      4'd6: push(pl, pc, T_IDX, k, 3'd0);
      4'd7: begin
        unique case (rg)
          8'd0: push(pl, pc, T_SKIP, k, 3'd1);
          8'd1: push(pl, pc, T_SKIP, k, 3'd2);
          8'd2: push(pl, pc, T_W16, k, 3'd0);
          8'd3: push(pl, pc, T_PCIDX, K_DATA, 3'd0);
          8'd4: begin
            if (osz == 3'd1 || osz == 3'd2) push(pl, pc, T_SKIP, k, 3'd1);
            else if (osz == 3'd4) push(pl, pc, T_SKIP, k, 3'd2);
          end
          default: ;
        endcase
      end
      4'd9: begin
        if (rg == 8'd0) push(pl, pc, T_W16, k, 3'd0);
        else if (rg == 8'd255) push(pl, pc, T_L32, k, 3'd0);
        else begin
          ev = 1'b1; ea_a = addr + 32'd2 + sx8(rg); ek = k;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [2:0] fsz(input logic [1:0] b, input logic [2:0] cur);
    return (b == 2'd0) ? 3'd1 : (b == 2'd1) ? 3'd2 : (b == 2'd2) ? 3'd4 : cur;
  endfunction

  function automatic void decode_op(input logic [15:0] op, input logic [31:0] a,
      input logic [2:0] osz_in, output logic [2:0] s, inout plan_item_t pl [3],
      inout logic [1:0] pc, inout logic ev, inout logic [31:0] eaa,
      inout logic [1:0] ek, output logic [1:0] st);
    logic [7:0] by1, by2;
    logic [3:0] md, rg;
    logic [2:0] rg9;
    logic [1:0] b76;
    logic       b8;
    by1 = op[15:8]; by2 = op[7:0]; rg = {1'b0, by2[2:0]}; md = {1'b0, by2[5:3]};
    b76 = by2[7:6]; b8 = by1[0]; rg9 = by1[3:1]; s = osz_in; st = ST_OK;
    unique case (by1[7:4])
      4'd0: begin
        if (b8) begin
          if (md == 4'd1) begin
            s = b76[0] ? 3'd4 : 3'd2;
            ea(4'd5, {4'd0, rg}, (b76 < 2'd2) ? K_DATA : K_ALTER, a, s, pl, pc, ev, eaa, ek);
          end else begin
            s = 3'd1; ea(md, {4'd0, rg}, K_DATA, a, s, pl, pc, ev, eaa, ek);
          end
        end else if (rg9 == 3'd4) begin
          s = 3'd1;
          ea(4'd7, 8'd4, K_DATA, a, s, pl, pc, ev, eaa, ek);
          ea(md, {4'd0, rg}, K_DATA, a, s, pl, pc, ev, eaa, ek);
        end else begin
          s = fsz(b76, s);
          ea(4'd7, 8'd4, K_DATA, a, s, pl, pc, ev, eaa, ek);
          if (!(by1[2] == 1'b0 && md == 4'd7 && rg == 4'd4))
            ea(md, {4'd0, rg}, K_ALTER, a, s, pl, pc, ev, eaa, ek);
        end
      end
      4'd1, 4'd2, 4'd3: begin
        s = (by1[7:4] == 4'd1) ? 3'd1 : ((by1[7:4] == 4'd2) ? 3'd4 : 3'd2);
        ea(md, {4'd0, rg}, K_DATA, a, s, pl, pc, ev, eaa, ek);
        ea({1'b0, b8, b76}, {5'd0, rg9}, K_ALTER, a, s, pl, pc, ev, eaa, ek);
      end
      4'd4: begin
        if (b8) begin
          if (b76 == 2'd1) st = ST_INVALID;
          else begin
            s = (b76 == 2'd3) ? 3'd4 : (3'd4 - {1'b0, b76});
            ea(md, {4'd0, rg}, K_DATA, a, s, pl, pc, ev, eaa, ek);
          end
        end else begin
          unique case (rg9)
            3'd0, 3'd1, 3'd2, 3'd3: begin
              if (b76 != 2'd3) begin
                s = fsz(b76, s); ea(md, {4'd0, rg}, K_ALTER, a, s, pl, pc, ev, eaa, ek);
              end else begin
                s = 3'd2;
                ea(md, {4'd0, rg}, (rg9 == 3'd2) ? K_DATA : K_ALTER, a, s, pl, pc,
                   ev, eaa, ek);
              end
            end
            3'd4: begin
              if (b76 == 2'd0) begin
                s = 3'd1; ea(md, {4'd0, rg}, K_ALTER, a, s, pl, pc, ev, eaa, ek);
              end else if (b76 == 2'd1) begin
                if (md == 4'd0) s = 3'd2;
                else begin
                  s = 3'd4; ea(md, {4'd0, rg}, K_DATA, a, s, pl, pc, ev, eaa, ek);
                end
              end else begin
                s = (b76 == 2'd2) ? 3'd2 : 3'd4;
                if (md != 4'd0) begin
                  push(pl, pc, T_SKIP, K_DATA, 3'd1);
                  ea(md, {4'd0, rg}, K_ALTER, a, s, pl, pc, ev, eaa, ek);
                end
              end
            end
            3'd5: begin
              s = (b76 != 2'd3) ? fsz(b76, s) : 3'd1;
              ea(md, {4'd0, rg}, K_DATA, a, s, pl, pc, ev, eaa, ek);
            end
            3'd6: begin
              s = (b76 == 2'd2) ? 3'd2 : ((b76 == 2'd3) ? 3'd4 : 3'd0);
              push(pl, pc, T_SKIP, K_DATA, 3'd1);
              ea(md, {4'd0, rg}, K_DATA, a, s, pl, pc, ev, eaa, ek);
            end
            default: begin
              if (b76 == 2'd0) st = ST_INVALID;
              else if (b76 == 2'd1) begin
                unique case (md)
                  4'd2: begin
                    s = 3'd2; ea(4'd7, 8'd4, K_DATA, a, s, pl, pc, ev, eaa, ek);
                  end
                  4'd3: s = 3'd0;
                  4'd4, 4'd5: s = 3'd4;
                  4'd6: begin
                    s = 3'd0;
                    if (rg > 4'd1) st = ST_STOP;
                    if (rg == 4'd2 || rg == 4'd4) begin
                      s = 3'd2; ea(4'd7, 8'd4, K_DATA, a, s, pl, pc, ev, eaa, ek);
                    end
                  end
                  4'd7: begin
                    if (rg[2:1] == 2'd1) begin
                      s = 3'd2; ea(4'd7, 8'd4, K_DATA, a, s, pl, pc, ev, eaa, ek);
                    end else st = ST_INVALID;
                  end
                  default: ;
                endcase
              end else if (b76 == 2'd2) begin
                s = 3'd0; ea(md, {4'd0, rg}, K_SUB, a, s, pl, pc, ev, eaa, ek);
              end else begin
                s = 3'd0; ea(md, {4'd0, rg}, K_BRANCH, a, s, pl, pc, ev, eaa, ek);
                st = ST_STOP;
              end
            end
          endcase
        end
      end
      4'd5: begin
        if (b76 == 2'd3) begin
          if (md == 4'd1) begin
            s = 3'd2; ea(4'd7, 8'd2, K_BRANCH, a, s, pl, pc, ev, eaa, ek);
          end else begin
            s = 3'd1; ea(md, {4'd0, rg}, K_ALTER, a, s, pl, pc, ev, eaa, ek);
          end
        end else ea(md, {4'd0, rg}, K_ALTER, a, s, pl, pc, ev, eaa, ek);
      end
      4'd6: begin
        s = 3'd0;
        if (by1[3:0] == 4'd1) ea(4'd9, by2, K_SUB, a, s, pl, pc, ev, eaa, ek);
        else begin
          if (by1[3:0] == 4'd0) st = ST_STOP;
          ea(4'd9, by2, K_BRANCH, a, s, pl, pc, ev, eaa, ek);
        end
      end
      4'd7: ;
      4'd8: begin
        if (b76 == 2'd3) begin
          s = 3'd2; ea(md, {4'd0, rg}, K_DATA, a, s, pl, pc, ev, eaa, ek);
        end else if (!(b8 && md < 4'd2)) begin
          s = fsz(b76, s);
          ea(md, {4'd0, rg}, b8 ? K_ALTER : K_DATA, a, s, pl, pc, ev, eaa, ek);
        end
      end
      4'd9, 4'd13: begin
        s = fsz(b76, s);
        if (b76 == 2'd3) begin
          s = b8 ? 3'd4 : 3'd2; ea(md, {4'd0, rg}, K_DATA, a, s, pl, pc, ev, eaa, ek);
        end else if (!b8) ea(md, {4'd0, rg}, K_DATA, a, s, pl, pc, ev, eaa, ek);
        else if (md >= 4'd2) ea(md, {4'd0, rg}, K_ALTER, a, s, pl, pc, ev, eaa, ek);
      end
      4'd10: begin
        s = 3'd0;
        if (by1[3:2] == 2'b11) st = ST_STOP;
      end
      4'd11: begin
        if (b76 == 2'd3) begin
          s = b8 ? 3'd4 : 3'd2; ea(md, {4'd0, rg}, K_DATA, a, s, pl, pc, ev, eaa, ek);
        end else if (b8 && md == 4'd1) s = fsz(b76, s);
        else begin
          s = fsz(b76, s);
          ea(md, {4'd0, rg}, b8 ? K_ALTER : K_DATA, a, s, pl, pc, ev, eaa, ek);
        end
      end
      4'd12: begin
        if (b76 == 2'd3) begin
          s = 3'd2; ea(md, {4'd0, rg}, K_DATA, a, s, pl, pc, ev, eaa, ek);
        end else if (md < 4'd2) begin
          if (b76 != 2'd0) s = 3'd4;
        end else begin
          s = fsz(b76, s);
          ea(md, {4'd0, rg}, b8 ? K_ALTER : K_DATA, a, s, pl, pc, ev, eaa, ek);
        end
      end
      4'd14: begin
        if (b76 == 2'd3) begin
          if ((op & OP_BIT11) != 16'd0) begin
            push(pl, pc, T_SKIP, K_DATA, 3'd1); s = 3'd0;
            ea(md, {4'd0, rg}, K_DATA, a, s, pl, pc, ev, eaa, ek);
          end else begin
            s = 3'd2; ea(md, {4'd0, rg}, K_ALTER, a, s, pl, pc, ev, eaa, ek);
          end
        end else s = fsz(b76, s);
      end
      default: st = ST_UNHAND;
    endcase
  endfunction

  always_comb begin
    logic [15:0] op, w;
    logic [31:0] addr;
    logic [1:0]  k;
    logic        fin;
    logic [2:0]  bdn, pos;
    item_type_e  t;

    phase_d = phase_q; plan_d = plan_q; pcnt_d = pcnt_q; wl_d = wl_q;
    hh_d = hh_q; rb_d = rb_q; ifw_d = ifw_q; osz_d = osz_q; pr_d = pr_q;
    isa_d = isa_q; stl_d = stl_q;
    emit_v = 1'b0; emit_a = '0; emit_k = K_DATA; done = 1'b0; st = ST_OK;
    off = '0; fin = 1'b0; bdn = '0; pos = '0;
    w = ir_q.code_word; addr = ir_q.word_address; op = w;
    t = plan_q[0].kind_t; k = plan_q[0].kind;

    if (phase_q == PH_OPCODE || ir_q.restart) begin
      pcnt_d = '0;
      for (int i = 0; i < 3; i++) plan_d[i] = '0;
      pr_d = 1'b0; isa_d = addr;
      decode_op(op, addr, osz_q, osz_d, plan_d, pcnt_d, emit_v, emit_a, emit_k, st);
      stl_d = st;
      if (pcnt_d == 2'd0) begin
        phase_d = PH_OPCODE; done = 1'b1;
      end else begin
        start_item(plan_d[0], wl_d, phase_d);
      end
    end else begin
      unique case (t)
        T_SKIP: begin
          if (wl_q != 3'd0) wl_d = wl_q - 3'd1;
          fin = (wl_d == 3'd0);
        end
        T_W16: begin
          emit_v = 1'b1; emit_a = addr + sx16(w); emit_k = k; fin = 1'b1;
        end
        T_L32: begin
          if (wl_q == 3'd2) begin
            rb_d = addr; hh_d = w; wl_d = 3'd1;
          end else begin
            emit_v = 1'b1; emit_a = rb_q + {hh_q, w}; emit_k = k; fin = 1'b1;
          end
        end
        T_IDX, T_PCIDX: begin
          if (phase_q == PH_EXT) begin
            rb_d = addr; ifw_d = w; pr_d = 1'b0;
            if ((w & FMT_FULL) != 16'd0) begin
              wl_d = fw(w[5:4]) + fw(w[1:0]);
              if (wl_d == 3'd0) fin = 1'b1; else phase_d = PH_IDXEXT;
            end else begin
              off = sx8(w[7:0]);
              if (t == T_PCIDX && off != 32'd0) begin
                pr_d = 1'b1; rb_d = addr + off;
              end
              fin = 1'b1;
            end
          end else begin
            bdn = fw(ifw_q[5:4]);
            pos = bdn + fw(ifw_q[1:0]) - wl_q;
            if (pos < bdn) begin
              if (bdn == 3'd1) off = sx16(w);
              else if (pos == 3'd0) hh_d = w;
              else off = {hh_q, w};
              if (!(bdn == 3'd2 && pos == 3'd0)) begin
                if ((ifw_q & FMT_BS) != 16'd0) off = '0;
                if (t == T_PCIDX && off != 32'd0) begin
                  pr_d = 1'b1; rb_d = rb_q + off;
                end
              end
            end
            if (wl_q != 3'd0) wl_d = wl_q - 3'd1;
            fin = (wl_d == 3'd0);
          end
          if (fin && t == T_PCIDX && pr_d) begin
            emit_v = 1'b1; emit_a = rb_d; emit_k = K_DATA; pr_d = 1'b0;
          end
        end
        default: fin = 1'b1;
      endcase
      if (fin) begin
        plan_d[0] = plan_q[1]; plan_d[1] = plan_q[2]; plan_d[2] = '0;
        if (pcnt_q != 2'd0) pcnt_d = pcnt_q - 2'd1;
        if (pcnt_d == 2'd0) begin
          phase_d = PH_OPCODE; done = 1'b1;
        end else begin
          start_item(plan_d[0], wl_d, phase_d);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0; ov_q <= 1'b0; phase_q <= PH_OPCODE; pcnt_q <= 2'd0;
      wl_q <= '0; hh_q <= '0; rb_q <= '0; ifw_q <= '0; osz_q <= '0;
      pr_q <= 1'b0; isa_q <= '0; stl_q <= '0;
      for (int i = 0; i < 3; i++) plan_q[i] <= '0;
    end else begin
      if (in_ch.ready) iv_q <= in_ch.valid;
      if (adv) begin
        ov_q <= emit_v || done;
        phase_q <= phase_d; plan_q <= plan_d; pcnt_q <= pcnt_d; wl_q <= wl_d;
        hh_q <= hh_d; rb_q <= rb_d; ifw_q <= ifw_d; osz_q <= osz_d;
        pr_q <= pr_d; isa_q <= isa_d; stl_q <= stl_d;
      end else if (out_ch.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) ir_q <= in_ch.data;
    if (adv) begin
      or_q.ref_valid <= emit_v;
      or_q.ref_address <= emit_v ? emit_a : 32'd0;
      or_q.target_kind <= emit_v ? emit_k : K_DATA;
      or_q.instr_done <= done;
      or_q.instr_start <= done ? isa_d : 32'd0;
      or_q.instr_next <= done ? ir_q.word_address + 32'd2 : 32'd0;
      or_q.end_status <= done ? stl_d : ST_OK;
      or_q.last <= 1'b1;
    end
  end

  assign out_ch.valid = ov_q;
  assign out_ch.data = or_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result word changed under stall");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> out_ch.data.last && (out_ch.data.ref_valid || out_ch.data.instr_done))
    else $error("empty result word");
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.data.instr_done |-> out_ch.data.instr_next == 32'd0)
    else $error("next address without close");
`endif
endmodule
